// File: hw/rtl/lpht_pkg.sv
package lpht_pkg;

    // Fixed field widths.
    localparam int ACTION_W  = 2;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 7;
    localparam int HASH_W    = 32;

    // Stream word widths, padded to whole bytes.
    localparam int S_FIELDS_W = ACTION_W + KEY_W + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + VAL_W + 1 + CNT_OUT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // One slot entry: used flag on top, then key, then value.
    localparam int ENTRY_W = 1 + KEY_W + VAL_W;

    // Hash constants: h = h * 33 + byte.
    localparam int HASH_SHIFT = 5;
    localparam int MOD_DIGIT  = 4;

    // Parameter defaults.
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BYTES_DEF   = 8;

    // Request codes.
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } ctl_state_t;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_RUN,
        HS_MOD,
        HS_DONE
    } hash_state_t;

endpackage

// File: hw/rtl/lpht_slot_ram.sv
module lpht_slot_ram #(
    parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     waddr,
    input  logic [lpht_pkg::ENTRY_W-1:0]       wdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0]     raddr,
    output logic [lpht_pkg::ENTRY_W-1:0]       rdata
);
    import lpht_pkg::*;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/lpht_hash.sv
module lpht_hash #(
    parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lpht_pkg::KEY_W-1:0]     key,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] slot
);
    import lpht_pkg::*;

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int R_W       = IDX_W + 1;
    localparam int MOD_STEPS = HASH_W / MOD_DIGIT;
    localparam int STEP_W    = $clog2(MOD_STEPS);
    localparam bit DEPTH_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
    localparam logic [R_W-1:0]    DEPTH_R   = R_W'(TABLE_DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MOD_STEPS - 1);

    hash_state_t        state_reg, state_next;
    logic [KEY_W-1:0]   shift_reg, shift_next;
    logic [HASH_W-1:0]  h_reg, h_next;
    logic [R_W-1:0]     rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [R_W-1:0]     rem_work;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        shift_reg <= shift_next;
        h_reg     <= h_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        slot_reg  <= slot_next;
    end

    always_comb begin
        state_next = state_reg;
        shift_next = shift_reg;
        h_next     = h_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        slot_next  = slot_reg;
        rem_work   = rem_reg;
        unique case (state_reg)
            HS_IDLE: begin
                if (start) begin
                    shift_next = key;
                    h_next     = '0;
                    state_next = HS_RUN;
                end
            end
            HS_RUN: begin
                // The key arrives cleaned, so the first zero byte ends it.
                if (shift_reg[7:0] == 8'd0) begin
                    rem_next  = '0;
                    step_next = '0;
                    if (DEPTH_POW2) begin
                        slot_next  = h_reg[IDX_W-1:0];
                        state_next = HS_DONE;
                    end else begin
                        state_next = HS_MOD;
                    end
                end else begin
                    h_next     = (h_reg << HASH_SHIFT) + h_reg
                                 + HASH_W'(shift_reg[7:0]);
                    shift_next = shift_reg >> 8;
                end
            end
            HS_MOD: begin
                // Restoring reduction, MOD_DIGIT hash bits per cycle from the top.
                for (int j = 0; j < MOD_DIGIT; j++) begin
                    rem_work = {rem_work[R_W-2:0], h_reg[HASH_W-1-j]};
                    if (rem_work >= DEPTH_R) begin
                        rem_work = rem_work - DEPTH_R;
                    end
                end
                h_next    = h_reg << MOD_DIGIT;
                rem_next  = rem_work;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    slot_next  = rem_work[IDX_W-1:0];
                    state_next = HS_DONE;
                end
            end
            HS_DONE: begin
                state_next = HS_IDLE;
            end
            default: begin
                state_next = HS_IDLE;
            end
        endcase
    end

    assign done = (state_reg == HS_DONE);
    assign slot = slot_reg;

endmodule

// File: hw/rtl/linear_probe_hash_table_core.sv
// Channel   Direction  Word fields (lowest bit first)
// s_        in         action[1:0], key[65:2], value_in[97:66], zero pad to 104
// m_        out        hit[0], value_out[32:1], table_full[33], entry_count[40:34],
//                      zero pad to 48
//
// One request at a time. A request is accepted, its key is hashed, then reduced
// modulo TABLE_DEPTH when TABLE_DEPTH is not a power of two, the slots are probed
// (one slot memory read per cycle) and the result goes to the output register.
// With the unused action code a request skips hashing and probing.
// After reset every slot of the slot memory is cleared with s_tready low.
// A word waiting on m_ does not block the next request from being accepted;
// only its completion waits for the output register.
module linear_probe_hash_table_core #(
    parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // action, key, value_in, zero pad
    input  logic [lpht_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit, value_out, table_full, entry_count, zero pad
    output logic [lpht_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    ctl_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    clr_idx_reg, clr_idx_next;
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    probe_cnt_reg, probe_cnt_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                res_hit_reg, res_hit_next;
    logic [VAL_W-1:0]    res_vout_reg, res_vout_next;
    logic                res_full_reg, res_full_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [ACTION_W-1:0] s_action;
    logic [KEY_W-1:0]    s_key;
    logic [VAL_W-1:0]    s_value;
    logic [KEY_W-1:0]    key_clean;
    logic                key_keep;

    logic                hash_start;
    logic                hash_done;
    logic [IDX_W-1:0]    hash_slot;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;

    logic                slot_used;
    logic [KEY_W-1:0]    slot_key;
    logic [VAL_W-1:0]    slot_val;
    logic                slot_match;

    assign s_action = s_tdata[ACTION_W-1:0];
    assign s_key    = s_tdata[ACTION_W +: KEY_W];
    assign s_value  = s_tdata[ACTION_W + KEY_W +: VAL_W];

    // Keep the key bytes before the first zero byte and within KEY_BYTES.
    always_comb begin
        key_keep  = 1'b1;
        key_clean = '0;
        for (int i = 0; i < KEY_W / 8; i++) begin
            if (i >= KEY_BYTES || s_key[8*i +: 8] == 8'd0) begin
                key_keep = 1'b0;
            end
            if (key_keep) begin
                key_clean[8*i +: 8] = s_key[8*i +: 8];
            end
        end
    end

    assign slot_used  = mem_rdata[ENTRY_W-1];
    assign slot_key   = mem_rdata[VAL_W +: KEY_W];
    assign slot_val   = mem_rdata[VAL_W-1:0];
    assign slot_match = slot_used && (slot_key == key_reg);

    lpht_hash #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (key_clean),
        .done    (hash_done),
        .slot    (hash_slot)
    );

    lpht_slot_ram #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        action_reg    <= action_next;
        key_reg       <= key_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        probe_cnt_reg <= probe_cnt_next;
        res_hit_reg   <= res_hit_next;
        res_vout_reg  <= res_vout_next;
        res_full_reg  <= res_full_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        action_next    = action_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        probe_cnt_next = probe_cnt_reg;
        count_next     = count_reg;
        res_hit_next   = res_hit_reg;
        res_vout_next  = res_vout_reg;
        res_full_next  = res_full_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        s_tready       = 1'b0;
        hash_start     = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = {1'b1, key_reg, val_reg};
        mem_raddr      = idx_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                mem_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    action_next   = s_action;
                    key_next      = key_clean;
                    val_next      = s_value;
                    res_hit_next  = 1'b0;
                    res_vout_next = '0;
                    res_full_next = 1'b0;
                    if (s_action == ACT_INSERT || s_action == ACT_FIND
                        || s_action == ACT_ERASE) begin
                        hash_start = 1'b1;
                        state_next = ST_HASH;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    mem_raddr      = hash_slot;
                    idx_next       = hash_slot;
                    probe_cnt_next = '0;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // The slot read issued last cycle is on mem_rdata now.
                if (!slot_used || slot_match || probe_cnt_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                    unique case (action_reg)
                        ACT_INSERT: begin
                            if (slot_match) begin
                                mem_we       = 1'b1;
                                res_hit_next = 1'b1;
                            end else if (!slot_used) begin
                                mem_we     = 1'b1;
                                count_next = CNT_W'(count_reg + 1'b1);
                            end else begin
                                res_full_next = 1'b1;
                            end
                        end
                        ACT_FIND: begin
                            if (slot_match) begin
                                res_hit_next  = 1'b1;
                                res_vout_next = slot_val;
                            end
                        end
                        ACT_ERASE: begin
                            if (slot_match) begin
                                mem_we       = 1'b1;
                                mem_wdata    = '0;
                                res_hit_next = 1'b1;
                                if (count_reg != '0) begin
                                    count_next = CNT_W'(count_reg - 1'b1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    idx_next       = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
                    mem_raddr      = idx_next;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({CNT_OUT_W'(count_reg), res_full_reg,
                                                res_vout_reg, res_hit_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
